@@ hw/rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL. Each assertion is clocked on clk and
// held off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define SPQ_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define SPQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ hw/rtl/spq_pkg.sv @@
package spq_pkg;

  localparam int CAPACITY = 16;
  localparam int KEY_BITS = 64;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  typedef enum logic {
    KIND_ENQ = 1'b0,
    KIND_EXT = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [63:0] key;
  } in_item_t;

  typedef struct packed {
    logic [63:0] out_key;
    logic        was_empty;
    logic        rejected_full;
    logic [4:0]  entry_count;
    logic [63:0] min_key;
    logic        queue_empty;
  } out_item_t;

  // Operation broadcast to every cell; enq/deq are already qualified.
  typedef struct packed {
    logic                enq;
    logic                deq;
    logic [KEY_BITS-1:0] key;
  } op_t;

endpackage

@@ hw/rtl/spq_cell.sv @@
module spq_cell (
  input  logic                         clk,
  input  spq_pkg::op_t                 op,
  input  logic                         occ,
  input  logic [spq_pkg::KEY_BITS-1:0] left_key,
  input  logic                         left_le,
  input  logic [spq_pkg::KEY_BITS-1:0] right_key,
  output logic [spq_pkg::KEY_BITS-1:0] key_q,
  output logic [spq_pkg::KEY_BITS-1:0] key_nxt,
  output logic                         le
);

  logic [spq_pkg::KEY_BITS-1:0] key_r;

  // Entry stays in front of the new key (ties keep arrival order).
  assign le = occ && (key_r <= op.key);

  always_comb begin
    key_nxt = key_r;
    if (op.enq) begin
      if (!le) begin
        key_nxt = left_le ? op.key : left_key;
      end
    end else if (op.deq) begin
      key_nxt = right_key;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

  assign key_q = key_r;

endmodule

@@ hw/rtl/sorted_priority_queue.sv @@
// sorted_priority_queue: min-priority queue held as a sorted row of cells.
// A result is registered in the output register, or in the skid register while the output is stalled.
// Throughput: 1 item per cycle while in_stall is low; every cell updates in parallel each cycle.
// A two-entry output buffer lets one more item in while a result is stalled.
// Reset clears the entry count and the output buffer; stored keys are not
// cleared (only positions below the count are ever read).
`include "assert_macros.svh"

module sorted_priority_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  spq_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output spq_pkg::out_item_t out_data
);

  localparam int CAP = spq_pkg::CAPACITY;
  localparam int KW  = spq_pkg::KEY_BITS;
  localparam int CW  = spq_pkg::CNT_W;

  // ---------------------------------------------------------------------
  // Entry count and operation decode
  // ---------------------------------------------------------------------
  logic [CW-1:0] count_r, count_nxt;
  logic          accept, is_enq, full, empty;
  spq_pkg::op_t  op;

  assign accept = in_valid && !in_stall;
  assign is_enq = (in_data.kind == spq_pkg::KIND_ENQ);
  assign full   = (count_r == CW'(CAP));
  assign empty  = (count_r == '0);

  always_comb begin
    op.enq = accept && is_enq && !full;
    op.deq = accept && !is_enq && !empty;
    op.key = in_data.key[KW-1:0];   // high bits beyond KEY_BITS dropped
  end

  always_comb begin
    count_nxt = count_r;
    if (op.enq) begin
      count_nxt = count_r + 1'b1;
    end else if (op.deq) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Cell row. Cell 0 holds the minimum. On enqueue each cell keeps its key,
  // takes the new key, or takes its left neighbor's key (shift toward the
  // tail). On extract every cell takes its right neighbor's key; the tail cell takes zero.
  // ---------------------------------------------------------------------
  logic [KW-1:0] cell_key     [CAP];
  logic [KW-1:0] cell_key_nxt [CAP];
  logic          cell_le      [CAP];

  for (genvar i = 0; i < CAP; i++) begin : g_cell
    logic [KW-1:0] lk, rk;
    logic          ll, oc;

    if (i == 0) begin : g_head
      assign lk = op.key;   // head cell takes the new key directly
      assign ll = 1'b0;
    end else begin : g_body
      assign lk = cell_key[i-1];
      assign ll = cell_le[i-1];
    end

    if (i == CAP - 1) begin : g_tail
      assign rk = '0;
    end else begin : g_mid
      assign rk = cell_key[i+1];
    end

    assign oc = (count_r > CW'(i));

    spq_cell u_cell (
      .clk       (clk),
      .op        (op),
      .occ       (oc),
      .left_key  (lk),
      .left_le   (ll),
      .right_key (rk),
      .key_q     (cell_key[i]),
      .key_nxt   (cell_key_nxt[i]),
      .le        (cell_le[i])
    );
  end

  // ---------------------------------------------------------------------
  // Result of the accepted item
  // ---------------------------------------------------------------------
  spq_pkg::out_item_t res;

  always_comb begin
    res.out_key       = op.deq ? 64'(cell_key[0]) : 64'd0;
    res.was_empty     = !is_enq && empty;
    res.rejected_full = is_enq && full;
    res.entry_count   = 5'(count_nxt);
    res.min_key       = (count_nxt != '0) ? 64'(cell_key_nxt[0]) : 64'd0;
    res.queue_empty   = (count_nxt == '0);
  end

  // ---------------------------------------------------------------------
  // Output buffer: main register plus skid. Input stalls only when the
  // skid is occupied, so the stall is a pure register output.
  // ---------------------------------------------------------------------
  logic               out_v_r, skid_v_r, pop;
  spq_pkg::out_item_t out_d_r, skid_d_r;

  assign pop      = out_v_r && !out_stall;
  assign in_stall = skid_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      if (skid_v_r) begin
        if (pop) begin
          out_v_r  <= 1'b1;
          skid_v_r <= 1'b0;
        end
      end else if (accept) begin
        if (!out_v_r || pop) begin
          out_v_r <= 1'b1;
        end else begin
          skid_v_r <= 1'b1;
        end
      end else if (pop) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (pop) begin
        out_d_r <= skid_d_r;
      end
    end else if (accept) begin
      if (!out_v_r || pop) begin
        out_d_r <= res;
      end else begin
        skid_d_r <= res;
      end
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_d_r;

  // ---------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------
  `SPQ_ASSERT(a_count_max, 1'b1, count_r <= CW'(CAP))
  `SPQ_ASSERT(a_skid_behind_out, skid_v_r, out_v_r)
  `SPQ_ASSERT(a_head_sorted, count_r >= CW'(2), cell_key[0] <= cell_key[1])
  `SPQ_ASSERT_NEXT(a_enq_grows, op.enq, count_r == $past(count_r) + 1'b1)

endmodule
